// ===== rtl/core/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int SIZE_BITS_DEF  = 31;
  localparam int TOTAL_BITS_DEF = 48;
  localparam int BYTE_W         = 8;
  localparam int BODY_TOTAL_W   = 48;
  localparam int HEX_W          = 4;

  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LF_HI = 8'h66;
  localparam logic [BYTE_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UF    = 8'h46;

  typedef enum logic [3:0] {
    PH_START,
    PH_LEAD,
    PH_DIGITS,
    PH_EXT,
    PH_DATA,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_FIN1,
    PH_FIN2,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic                    valid;
    logic [HEX_W-1:0]        value;
  } hex_digit_t;

  typedef struct packed {
    logic [BYTE_W-1:0]       out_byte;
    logic                    is_payload;
    logic                    chunk_first;
    logic                    done_res;
    logic                    error;
    logic [BODY_TOTAL_W-1:0] body_total;
  } result_t;

  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] b);
    hex_digit_t h;
    logic [BYTE_W-1:0] t;
    h = '{valid: 1'b0, value: '0};
    t = '0;
    if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
      t = b - CHAR_ZERO;
      h = '{valid: 1'b1, value: t[HEX_W-1:0]};
    end else if (b inside {[CHAR_LA:CHAR_LF_HI]}) begin
      t = b - CHAR_LA + 8'd10;
      h = '{valid: 1'b1, value: t[HEX_W-1:0]};
    end else if (b inside {[CHAR_UA:CHAR_UF]}) begin
      t = b - CHAR_UA + 8'd10;
      h = '{valid: 1'b1, value: t[HEX_W-1:0]};
    end
    return h;
  endfunction

endpackage

// ===== rtl/core/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Byte-wide HTTP chunked transfer decoder with skid-buffered result output.
// ----------------------------------------------------------------------------
// One request in, one result out, one byte per clock. Each accepted byte
// updates the parse state in the same cycle and its result lands in an output
// register; a single skid register behind it lets the block take one more byte
// while a result waits, so throughput is one byte per cycle whenever the sink
// keeps out_ready high; in_ready falls while the skid register is full.
// Size lines are parsed as hex with leading space/tab skipped; the extension
// is ignored up to CR LF. done_res and error are sticky until rst.
// body_total saturates at TOTAL_BITS bits.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF,
  parameter int TOTAL_BITS = hcbd_pkg::TOTAL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [hcbd_pkg::BYTE_W-1:0]           in_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hcbd_pkg::BYTE_W-1:0]           out_byte,
  output logic                                  is_payload,
  output logic                                  chunk_first,
  output logic                                  done_res,
  output logic                                  error,
  output logic [hcbd_pkg::BODY_TOTAL_W-1:0]     body_total
);

  localparam int SUM_W = ((SIZE_BITS > TOTAL_BITS) ? SIZE_BITS : TOTAL_BITS) + 1;
  localparam int EXT_W = (TOTAL_BITS > hcbd_pkg::BODY_TOTAL_W) ?
                         TOTAL_BITS : hcbd_pkg::BODY_TOTAL_W;

  hcbd_pkg::phase_t        phase, phase_next;
  logic [SIZE_BITS-1:0]    size_accum, size_accum_next;
  logic                    first_zero, first_zero_next;
  logic                    saw_cr, saw_cr_next;
  logic [SIZE_BITS-1:0]    bytes_left, bytes_left_next;
  logic [TOTAL_BITS-1:0]   declared_total, declared_total_next;

  hcbd_pkg::result_t       res, out_reg, skid;
  logic                    skid_valid;
  logic                    push, pop;

  hcbd_pkg::hex_digit_t    hex;
  logic                    is_ws, line_end, size_zero, size_ovf;
  logic [SUM_W-1:0]        sum;
  logic [TOTAL_BITS-1:0]   sat_total;
  logic [SIZE_BITS-1:0]    left_dec;
  logic                    use_digit, use_ext;
  logic                    payload, first;
  logic [EXT_W-1:0]        total_ext;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign hex       = hcbd_pkg::hex_decode(in_byte);
  assign is_ws     = (in_byte == hcbd_pkg::CHAR_SPACE) || (in_byte == hcbd_pkg::CHAR_TAB);
  assign line_end  = (in_byte == hcbd_pkg::CHAR_LF) && saw_cr;
  assign size_zero = (size_accum == '0);
  assign size_ovf  = |size_accum[SIZE_BITS-1 -: hcbd_pkg::HEX_W];
  assign sum       = SUM_W'(declared_total) + SUM_W'(size_accum);
  assign sat_total = (|sum[SUM_W-1:TOTAL_BITS]) ? '1 : sum[TOTAL_BITS-1:0];
  assign left_dec  = (bytes_left != '0) ? bytes_left - 1'b1 : '0;

  // next state
  always_comb begin
    phase_next          = phase;
    size_accum_next     = size_accum;
    first_zero_next     = first_zero;
    saw_cr_next         = saw_cr;
    bytes_left_next     = bytes_left;
    declared_total_next = declared_total;
    use_digit           = 1'b0;
    use_ext             = 1'b0;

    case (phase)
      hcbd_pkg::PH_START: begin
        first_zero_next = (in_byte == hcbd_pkg::CHAR_ZERO);
        if (is_ws) phase_next = hcbd_pkg::PH_LEAD;
        else use_digit = 1'b1;
      end
      hcbd_pkg::PH_LEAD: begin
        if (!is_ws) use_digit = 1'b1;
      end
      hcbd_pkg::PH_DIGITS: use_digit = 1'b1;
      hcbd_pkg::PH_EXT:    use_ext = 1'b1;
      hcbd_pkg::PH_DATA: begin
        bytes_left_next = left_dec;
        if (left_dec == '0) phase_next = hcbd_pkg::PH_TRAIL1;
      end
      hcbd_pkg::PH_TRAIL1: phase_next = hcbd_pkg::PH_TRAIL2;
      hcbd_pkg::PH_TRAIL2: begin
        size_accum_next = '0;
        first_zero_next = 1'b0;
        saw_cr_next     = 1'b0;
        phase_next      = hcbd_pkg::PH_START;
      end
      hcbd_pkg::PH_FIN1:  phase_next = hcbd_pkg::PH_FIN2;
      hcbd_pkg::PH_FIN2:  phase_next = hcbd_pkg::PH_DONE;
      hcbd_pkg::PH_DONE:  phase_next = hcbd_pkg::PH_DONE;
      default:            phase_next = hcbd_pkg::PH_ERROR;
    endcase

    if (use_digit) begin
      if (!hex.valid) begin
        use_ext = 1'b1;
      end else if (size_ovf) begin
        phase_next = hcbd_pkg::PH_ERROR;
      end else begin
        size_accum_next = {size_accum[SIZE_BITS-hcbd_pkg::HEX_W-1:0], hex.value};
        phase_next      = hcbd_pkg::PH_DIGITS;
      end
    end

    if (use_ext) begin
      if (line_end) begin
        saw_cr_next = 1'b0;
        if (size_zero) begin
          phase_next = first_zero ? hcbd_pkg::PH_FIN1 : hcbd_pkg::PH_ERROR;
        end else begin
          declared_total_next = sat_total;
          bytes_left_next     = size_accum;
          phase_next          = hcbd_pkg::PH_DATA;
        end
      end else begin
        saw_cr_next = (in_byte == hcbd_pkg::CHAR_CR);
        phase_next  = hcbd_pkg::PH_EXT;
      end
    end
  end

  // per-byte outputs
  always_comb begin
    payload = 1'b0;
    first   = 1'b0;
    case (phase)
      hcbd_pkg::PH_DATA: begin
        payload = 1'b1;
        first   = (bytes_left == size_accum);
      end
      default: begin
        payload = 1'b0;
        first   = 1'b0;
      end
    endcase
  end

  assign total_ext = EXT_W'(declared_total_next);

  always_comb begin
    res.out_byte    = in_byte;
    res.is_payload  = payload;
    res.chunk_first = first;
    res.done_res    = (phase_next == hcbd_pkg::PH_DONE);
    res.error       = (phase_next == hcbd_pkg::PH_ERROR);
    res.body_total  = total_ext[hcbd_pkg::BODY_TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hcbd_pkg::PH_START;
      size_accum     <= '0;
      first_zero     <= 1'b0;
      saw_cr         <= 1'b0;
      bytes_left     <= '0;
      declared_total <= '0;
    end else if (push) begin
      phase          <= phase_next;
      size_accum     <= size_accum_next;
      first_zero     <= first_zero_next;
      saw_cr         <= saw_cr_next;
      bytes_left     <= bytes_left_next;
      declared_total <= declared_total_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_reg    <= skid;
          skid_valid <= 1'b0;
        end else if (push) begin
          out_reg <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid) begin
          skid       <= res;
          skid_valid <= 1'b1;
        end else begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end
      end
    end
  end

  assign out_byte    = out_reg.out_byte;
  assign is_payload  = out_reg.is_payload;
  assign chunk_first = out_reg.chunk_first;
  assign done_res    = out_reg.done_res;
  assign error       = out_reg.error;
  assign body_total  = out_reg.body_total;

endmodule

// ===== rtl/core/hcbd_checker.sv =====
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks for the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [hcbd_pkg::BYTE_W-1:0]         in_byte,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [hcbd_pkg::BYTE_W-1:0]         out_byte,
  input logic                                is_payload,
  input logic                                chunk_first,
  input logic                                done_res,
  input logic                                error,
  input logic [hcbd_pkg::BODY_TOTAL_W-1:0]   body_total
);

  a_request_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte))
    else $error("request dropped or changed while refused");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(body_total))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && error))
    else $error("done and error together");

  a_payload_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_payload || chunk_first) |-> is_payload && !done_res && !error)
    else $error("payload flagged after end or error");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_byte     (in_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .is_payload  (is_payload),
  .chunk_first (chunk_first),
  .done_res    (done_res),
  .error       (error),
  .body_total  (body_total)
);

// ===== tb/sv/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking bench for the chunked body decoder. A short scripted opening
// walks whitespace, lone CR and LF, extensions and extreme payload bytes.
// Random chunks with noisy extensions and trailers follow, and the body ends
// in one of four ways: terminating chunk, zero size error, size overflow or a
// chunk of the largest size. Every result is checked field by field against a
// byte-level decoder model kept in the bench, or against the script for typed
// rows, with random stalls on both sides and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;

  localparam int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF;
  localparam int TOTAL_BITS = hcbd_pkg::TOTAL_BITS_DEF;
  localparam int BODY_W     = hcbd_pkg::BODY_TOTAL_W;
  localparam logic [63:0] SIZE_MAX  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SIZE_BITS);
  localparam logic [63:0] TOTAL_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TOTAL_BITS);
  localparam int RANDOM_BYTES = 2000;
  localparam int CALM_TAIL    = 150;
  localparam int HOLD_CYCLES  = 120;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SCRIPT_LEN   = 20;

  typedef enum int {
    END_DONE,
    END_ZERO_SIZE,
    END_OVERFLOW,
    END_HUGE_CHUNK
  } ending_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic       pay;
    logic       first;
    logic [7:0] total;
  } script_row_t;

  typedef struct packed {
    logic [7:0]        b;
    logic              typed;
    hcbd_pkg::result_t want;
  } request_t;

  // byte, typed, is_payload, chunk_first, body_total
  localparam script_row_t [0:SCRIPT_LEN-1] OPENING_SCRIPT = {
    {hcbd_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_TAB,   1'b0, 1'b0, 1'b0, 8'd0},
    {"1",                  1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_CR,    1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_LF,    1'b0, 1'b0, 1'b0, 8'd0},
    {8'hFF,                1'b1, 1'b1, 1'b1, 8'd1},
    {8'h00,                1'b0, 1'b0, 1'b0, 8'd0},
    {8'hFF,                1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_ZERO,  1'b0, 1'b0, 1'b0, 8'd0},
    {"2",                  1'b0, 1'b0, 1'b0, 8'd0},
    {"x",                  1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_CR,    1'b0, 1'b0, 1'b0, 8'd0},
    {"q",                  1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_LF,    1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_CR,    1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_LF,    1'b0, 1'b0, 1'b0, 8'd0},
    {8'h00,                1'b1, 1'b1, 1'b1, 8'd3},
    {8'h80,                1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_CR,    1'b0, 1'b0, 1'b0, 8'd0},
    {hcbd_pkg::CHAR_LF,    1'b0, 1'b0, 1'b0, 8'd0}
  };

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [hcbd_pkg::BYTE_W-1:0]       in_byte;
  logic                              out_valid;
  logic                              out_ready;
  logic [hcbd_pkg::BYTE_W-1:0]       out_byte;
  logic                              is_payload;
  logic                              chunk_first;
  logic                              done_res;
  logic                              error;
  logic [hcbd_pkg::BODY_TOTAL_W-1:0] body_total;

  request_t          body_stream[$];
  hcbd_pkg::result_t pending_results[$];
  hcbd_pkg::result_t expected_now;
  hcbd_pkg::phase_t  dec_phase;
  logic [63:0]       dec_size;
  logic [63:0]       dec_left;
  logic [63:0]       dec_total;
  logic              dec_zero_first;
  logic              dec_cr;
  ending_t           ending;
  int                n_in         = 0;
  int                n_out        = 0;
  int                n_fail       = 0;
  int                n_payload    = 0;
  int                n_chunks     = 0;
  int                quiet_cycles = 0;
  logic              last_done    = 1'b0;
  logic              last_error   = 1'b0;
  bit                calm         = 1'b0;
  bit                hold_off     = 1'b0;

  http_chunked_body_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .is_payload (is_payload),
    .chunk_first(chunk_first),
    .done_res   (done_res),
    .error      (error),
    .body_total (body_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void end_of_line(input logic [7:0] b);
    if (b == hcbd_pkg::CHAR_LF && dec_cr) begin
      dec_cr = 1'b0;
      if (dec_size == 0) begin
        dec_phase = dec_zero_first ? hcbd_pkg::PH_FIN1 : hcbd_pkg::PH_ERROR;
      end else begin
        dec_total = (dec_size > TOTAL_MAX - dec_total) ? TOTAL_MAX
                                                        : dec_total + dec_size;
        dec_left  = dec_size;
        dec_phase = hcbd_pkg::PH_DATA;
      end
    end else begin
      dec_cr    = (b == hcbd_pkg::CHAR_CR);
      dec_phase = hcbd_pkg::PH_EXT;
    end
  endfunction

  function automatic void size_char(input logic [7:0] b);
    logic [63:0] d;
    logic        hex;
    d   = '0;
    hex = 1'b1;
    if (b >= hcbd_pkg::CHAR_ZERO && b <= hcbd_pkg::CHAR_NINE)
      d = 64'(b - hcbd_pkg::CHAR_ZERO);
    else if (b >= hcbd_pkg::CHAR_LA && b <= hcbd_pkg::CHAR_LF_HI)
      d = 64'(b - hcbd_pkg::CHAR_LA) + 64'd10;
    else if (b >= hcbd_pkg::CHAR_UA && b <= hcbd_pkg::CHAR_UF)
      d = 64'(b - hcbd_pkg::CHAR_UA) + 64'd10;
    else hex = 1'b0;
    if (!hex) begin
      end_of_line(b);
    end else if (dec_size > (SIZE_MAX >> 4)) begin
      dec_phase = hcbd_pkg::PH_ERROR;
    end else begin
      dec_size  = (dec_size << 4) + d;
      dec_phase = hcbd_pkg::PH_DIGITS;
    end
  endfunction

  function automatic hcbd_pkg::result_t decode_step(input logic [7:0] b);
    hcbd_pkg::result_t r;
    r          = '0;
    r.out_byte = b;
    case (dec_phase)
      hcbd_pkg::PH_START: begin
        dec_zero_first = (b == hcbd_pkg::CHAR_ZERO);
        if (b == hcbd_pkg::CHAR_SPACE || b == hcbd_pkg::CHAR_TAB) dec_phase = hcbd_pkg::PH_LEAD;
        else size_char(b);
      end
      hcbd_pkg::PH_LEAD: begin
        if (b != hcbd_pkg::CHAR_SPACE && b != hcbd_pkg::CHAR_TAB) size_char(b);
      end
      hcbd_pkg::PH_DIGITS: size_char(b);
      hcbd_pkg::PH_EXT: end_of_line(b);
      hcbd_pkg::PH_DATA: begin
        r.is_payload  = 1'b1;
        r.chunk_first = (dec_left == dec_size);
        if (dec_left > 0) dec_left--;
        if (dec_left == 0) dec_phase = hcbd_pkg::PH_TRAIL1;
      end
      hcbd_pkg::PH_TRAIL1: dec_phase = hcbd_pkg::PH_TRAIL2;
      hcbd_pkg::PH_TRAIL2: begin
        dec_size       = '0;
        dec_zero_first = 1'b0;
        dec_cr         = 1'b0;
        dec_phase      = hcbd_pkg::PH_START;
      end
      hcbd_pkg::PH_FIN1: dec_phase = hcbd_pkg::PH_FIN2;
      hcbd_pkg::PH_FIN2: dec_phase = hcbd_pkg::PH_DONE;
      hcbd_pkg::PH_DONE: ;
      default: dec_phase = hcbd_pkg::PH_ERROR;
    endcase
    r.done_res   = (dec_phase == hcbd_pkg::PH_DONE);
    r.error      = (dec_phase == hcbd_pkg::PH_ERROR);
    r.body_total = dec_total[BODY_W-1:0];
    return r;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    request_t r;
    r   = '0;
    r.b = b;
    body_stream.push_back(r);
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(int'(hcbd_pkg::CHAR_ZERO) + v);
    return 8'(int'($urandom_range(0, 1) ? hcbd_pkg::CHAR_UA : hcbd_pkg::CHAR_LA) + v - 10);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_now = decode_step(in_byte);
      if (body_stream[n_in].typed) expected_now = body_stream[n_in].want;
      pending_results.push_back(expected_now);
      n_in++;
    end
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("out_byte: expected nothing, got %0h", out_byte);
        n_fail++;
      end else begin
        expected_now = pending_results.pop_front();
        check_field("out_byte", 64'(expected_now.out_byte), 64'(out_byte));
        check_field("is_payload", 64'(expected_now.is_payload), 64'(is_payload));
        check_field("chunk_first", 64'(expected_now.chunk_first), 64'(chunk_first));
        check_field("done_res", 64'(expected_now.done_res), 64'(done_res));
        check_field("error", 64'(expected_now.error), 64'(error));
        check_field("body_total", 64'(expected_now.body_total), 64'(body_total));
      end
      n_payload  += int'(is_payload);
      n_chunks   += int'(chunk_first);
      last_done  = done_res;
      last_error = error;
      n_out++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int          i;
    int          k;
    int          size;
    int          nib;
    bit          steady;
    logic [7:0]  c;
    logic [7:0]  prev;
    script_row_t row;
    request_t    r;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    out_ready <= 1'b0;
    dec_phase      = hcbd_pkg::PH_START;
    dec_size       = '0;
    dec_left       = '0;
    dec_total      = '0;
    dec_zero_first = 1'b0;
    dec_cr         = 1'b0;
    steady         = 1'b0;

    for (i = 0; i < SCRIPT_LEN; i++) begin
      row                    = OPENING_SCRIPT[i];
      r                      = '0;
      r.b                    = row.b;
      r.typed                = row.typed;
      r.want.out_byte        = row.b;
      r.want.is_payload      = row.pay;
      r.want.chunk_first     = row.first;
      r.want.body_total      = BODY_W'(row.total);
      body_stream.push_back(r);
    end

    while (body_stream.size() < SCRIPT_LEN + RANDOM_BYTES) begin
      k = $urandom_range(0, 19);
      if (k < 14) size = $urandom_range(1, 16);
      else if (k < 19) size = $urandom_range(17, 300);
      else size = $urandom_range(301, 700);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          add_byte($urandom_range(0, 1) ? hcbd_pkg::CHAR_SPACE : hcbd_pkg::CHAR_TAB);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) add_byte(hcbd_pkg::CHAR_ZERO);
      nib = 1;
      while ((size >> (4 * nib)) != 0) nib++;
      for (i = nib - 1; i >= 0; i--) add_byte(hex_char((size >> (4 * i)) & 15));
      if ($urandom_range(0, 2) == 0) begin
        // extension noise; never let a stray CR LF end the line early
        c = ";";
        repeat ($urandom_range(1, 6)) begin
          add_byte(c);
          prev = c;
          c    = 8'($urandom_range(0, 255));
          if (prev == hcbd_pkg::CHAR_CR && c == hcbd_pkg::CHAR_LF) c = "x";
        end
      end
      add_byte(hcbd_pkg::CHAR_CR);
      add_byte(hcbd_pkg::CHAR_LF);
      repeat (size) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) begin
        add_byte(hcbd_pkg::CHAR_CR);
        add_byte(hcbd_pkg::CHAR_LF);
      end else begin
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
      end
    end

    ending = ending_t'($urandom_range(0, 3));
    case (ending)
      END_DONE: begin
        add_byte(hcbd_pkg::CHAR_ZERO);
        if ($urandom_range(0, 1)) add_byte(";");
        add_byte(hcbd_pkg::CHAR_CR);
        add_byte(hcbd_pkg::CHAR_LF);
        add_byte(hcbd_pkg::CHAR_CR);
        add_byte(hcbd_pkg::CHAR_LF);
      end
      END_ZERO_SIZE: begin
        k = $urandom_range(0, 2);
        if (k == 0) begin
          add_byte(hcbd_pkg::CHAR_SPACE);
          add_byte(hcbd_pkg::CHAR_ZERO);
        end else if (k == 1) begin
          add_byte("-");
          add_byte("3");
        end
        add_byte(hcbd_pkg::CHAR_CR);
        add_byte(hcbd_pkg::CHAR_LF);
      end
      END_OVERFLOW: begin
        add_byte(hex_char($urandom_range(8, 15)));
        repeat (SIZE_BITS / 4) add_byte(hex_char($urandom_range(0, 15)));
      end
      default: begin
        for (i = (SIZE_BITS + 3) / 4 - 1; i >= 0; i--)
          add_byte(hex_char(int'((SIZE_MAX >> (4 * i)) & 64'hF)));
        add_byte(hcbd_pkg::CHAR_CR);
        add_byte(hcbd_pkg::CHAR_LF);
        repeat (32) add_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat (8) add_byte(8'($urandom_range(0, 255)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    fork
      begin : sink
        forever begin
          if (hold_off) begin
            out_ready <= 1'b0;
            @(posedge clk);
          end else if (!calm && $urandom_range(0, 2) == 0) begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
          end else begin
            out_ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
          end
        end
      end
      begin : back_pressure
        while (n_in < 400) @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none

    for (i = 0; i < body_stream.size(); i++) begin
      if (i >= body_stream.size() - CALM_TAIL) calm = 1'b1;
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (!calm && !steady && !hold_off && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= body_stream[i].b;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (n_out < body_stream.size()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("out_byte: %0d results never arrived", pending_results.size());
      n_fail++;
    end

    $display("Decoded %0d bytes: %0d payload bytes in %0d chunks, %0d mismatches.",
             n_out, n_payload, n_chunks, n_fail);
    $display("Body ended by %s, final done_res=%0b error=%0b.",
             ending.name(), last_done, last_error);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
